// ===== hw/rtl/wpvs_pkg.sv =====
package wpvs_pkg;

   localparam logic [31:0] RIFF_ID = 32'h5249_4646;
   localparam logic [31:0] WAVE_ID = 32'h5741_5645;
   localparam logic [31:0] FMT_ID  = 32'h666D_7420;
   localparam logic [31:0] DATA_ID = 32'h6461_7461;

   localparam logic [15:0] VOL_PASS_LIMIT = 16'd32440;
   localparam logic [15:0] VOL_RESET      = 16'd32768;
   localparam logic [15:0] PCM_FORMAT     = 16'd1;
   localparam logic [31:0] FMT_MIN_SIZE   = 32'd16;

   // One result run: up to four bytes, lowest byte first.
   typedef struct packed {
      logic [31:0] bytes;
      logic [2:0]  count;
      logic        file_end;
   } run_word_type;

endpackage

// ===== hw/rtl/wav_pcm_volume_scaler.sv =====
// WAV volume scaler.
// The req channel carries the file one byte per word together with the file
// length, which is sampled with the first byte of each file. The block checks
// the RIFF/WAVE header, walks the chunks and scales the PCM samples of the data
// chunk by csr_wr_data / 32768 when the format is plain PCM of 8, 16, 24 or 32
// bits. Every other byte is passed unchanged.
// The rsp channel gives one byte per word. tlast marks the last byte caused by
// one req word; tuser marks the final byte of the file. Bytes of a wide sample
// are held and leave together once the sample is complete.
// An accepted req word passes through the parse register and the multiplier
// register, then the run queue. One req word is accepted per cycle while
// req_tready is high; the rsp side drains one byte per cycle while
// rsp_tready is high.
// When rsp_tready is low, completed runs collect in a queue of FifoDepth runs;
// req_tready falls once the queue and the two pipeline stages could fill it.
// Reset clears the parser to the start of a file, empties the queue and sets
// the gain to unity. The gain register may be written only while idle.
module wav_pcm_volume_scaler
   import wpvs_pkg::*;
#(
   parameter int FifoDepth = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // [7:0] data_byte, [39:8] file_length
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,  // [7:0] out_byte
   output logic        rsp_tlast,
   output logic        rsp_tuser,  // [0] file_end
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   localparam int PtrW = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
   localparam int CntW = $clog2(FifoDepth + 1);

   typedef enum logic [2:0] {
      PH_RIFF = 3'd0,
      PH_HDR  = 3'd1,
      PH_SKIP = 3'd2,
      PH_FMT  = 3'd3,
      PH_DATA = 3'd4,
      PH_PASS = 3'd5
   } phase_type;

   logic [15:0] vol_ff;

   phase_type   phase_ff, phase_in;
   logic [31:0] pos_ff, pos_in;
   logic [31:0] len_ff, len_in;
   logic [63:0] hw_ff, hw_in;
   logic [32:0] cend_ff, cend_in;
   logic        fmt_seen_ff, fmt_seen_in;
   logic [15:0] fmt_code_ff, fmt_code_in;
   logic [15:0] sbw_ff, sbw_in;
   logic [23:0] hold_ff, hold_in;
   logic [1:0]  held_ff, held_in;

   logic        accept;
   logic [7:0]  b;
   logic [31:0] flen;
   logic [31:0] len_eff;
   logic        is_end;
   logic [32:0] pos1;
   logic [63:0] hw_shift;
   logic [31:0] hw_lo;
   logic [31:0] chunk_size;
   logic [33:0] chunk_stop;
   logic [33:0] chunk_next;
   logic [33:0] fmt_off;
   logic [2:0]  w_raw;
   logic [2:0]  w_dec;
   logic [32:0] data_left;
   logic [31:0] raw;
   logic        width_ok;

   logic [31:0]        res_bytes;
   logic [2:0]         res_cnt;
   logic               res_scale;
   logic signed [31:0] res_x;

   logic               s1_valid_ff;
   logic [31:0]        s1_bytes_ff;
   logic [2:0]         s1_cnt_ff;
   logic               s1_end_ff;
   logic               s1_scale_ff;
   logic [2:0]         s1_w_ff;
   logic signed [31:0] s1_x_ff;

   logic               s2_valid_ff;
   logic [31:0]        s2_bytes_ff;
   logic [2:0]         s2_cnt_ff;
   logic               s2_end_ff;
   logic               s2_scale_ff;
   logic [2:0]         s2_w_ff;
   logic signed [48:0] s2_prod_ff;
   logic signed [48:0] s2_prod_in;

   logic signed [48:0] prod_bias;
   logic signed [33:0] q_floor;
   logic signed [33:0] q_trunc;
   logic signed [33:0] q_off;
   logic [31:0]        scaled;

   run_word_type       fifo_mem [FifoDepth];
   run_word_type       push_word;
   run_word_type       head;
   logic [PtrW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [CntW-1:0]    cnt_ff;
   logic [1:0]         sel_ff;
   logic               push;
   logic               pop;
   logic               rsp_acc;
   logic [CntW:0]      credit_used;

   assign accept = req_tvalid && req_tready;
   assign b      = req_tdata[7:0];
   assign flen   = req_tdata[39:8];

   always_ff @(posedge clock) begin
      if (reset) begin
         vol_ff <= VOL_RESET;
      end else if (csr_wr_en) begin
         vol_ff <= csr_wr_data;
      end
   end

   // Parser: all per-byte decisions are taken from the current state and the
   // incoming word.
   always_comb begin
      if (pos_ff == 32'd0) begin
         len_eff = (flen == 32'd0) ? 32'd1 : flen;
      end else begin
         len_eff = len_ff;
      end
      is_end     = (pos_ff == len_eff - 32'd1);
      pos1       = {1'b0, pos_ff} + 33'd1;
      hw_shift   = {hw_ff[55:0], b};
      hw_lo      = hw_shift[31:0];
      chunk_size = {hw_lo[7:0], hw_lo[15:8], hw_lo[23:16], hw_lo[31:24]};
      chunk_stop = {1'b0, pos1} + {2'b00, chunk_size};
      chunk_next = chunk_stop + {33'd0, chunk_stop[0]};
      fmt_off    = {2'b00, pos_ff} + 34'd16 - {1'b0, cend_ff};
      w_raw      = sbw_ff[5:3];
      w_dec      = (w_raw == 3'd0 || w_raw > 3'd4) ? 3'd1 : w_raw;
      data_left  = cend_ff - {1'b0, pos_ff};
      width_ok   = (sbw_ff == 16'd8) || (sbw_ff == 16'd16) ||
                   (sbw_ff == 16'd24) || (sbw_ff == 16'd32);
      raw        = {8'd0, hold_ff} | ({24'd0, b} << {w_dec - 3'd1, 3'b000});

      phase_in    = phase_ff;
      len_in      = len_eff;
      hw_in       = hw_ff;
      cend_in     = cend_ff;
      fmt_seen_in = fmt_seen_ff;
      fmt_code_in = fmt_code_ff;
      sbw_in      = sbw_ff;
      hold_in     = hold_ff;
      held_in     = held_ff;
      res_bytes   = {24'd0, b};
      res_cnt     = 3'd1;
      res_scale   = 1'b0;

      unique case (w_dec)
         3'd1:    res_x = 32'(signed'({1'b0, b}) - 9'sd128);
         3'd2:    res_x = 32'(signed'(raw[15:0]));
         3'd3:    res_x = 32'(signed'(raw[23:0]));
         default: res_x = signed'(raw);
      endcase

      unique case (phase_ff)
         PH_RIFF: begin
            hw_in = hw_shift;
            if (pos_ff == 32'd3 && hw_lo != RIFF_ID) begin
               phase_in = PH_PASS;
            end
            if (pos_ff == 32'd11) begin
               if (hw_lo != WAVE_ID) begin
                  phase_in = PH_PASS;
               end else begin
                  phase_in = PH_HDR;
                  cend_in  = 33'd12;
               end
            end
         end
         PH_HDR: begin
            hw_in = hw_shift;
            if ({1'b0, pos1} == {1'b0, cend_ff} + 34'd8) begin
               if (chunk_stop > {2'b00, len_eff}) begin
                  phase_in = PH_PASS;
               end else if (hw_shift[63:32] == FMT_ID && chunk_size >= FMT_MIN_SIZE) begin
                  fmt_seen_in = 1'b1;
                  hw_in       = {30'd0, chunk_next};
                  cend_in     = pos1 + 33'd16;
                  phase_in    = PH_FMT;
               end else if (hw_shift[63:32] == DATA_ID) begin
                  if (fmt_seen_ff && fmt_code_ff == PCM_FORMAT && chunk_size != 32'd0 &&
                      width_ok && vol_ff < VOL_PASS_LIMIT) begin
                     cend_in  = chunk_stop[32:0];
                     held_in  = 2'd0;
                     hold_in  = 24'd0;
                     phase_in = PH_DATA;
                  end else begin
                     phase_in = PH_PASS;
                  end
               end else begin
                  cend_in  = chunk_next[32:0];
                  phase_in = (chunk_next[32:0] == pos1) ? PH_HDR : PH_SKIP;
               end
            end
         end
         PH_SKIP: begin
            if (pos1 >= cend_ff) begin
               phase_in = PH_HDR;
            end
         end
         PH_FMT: begin
            if (fmt_off == 34'd0) begin
               fmt_code_in = {8'd0, b};
            end else if (fmt_off == 34'd1) begin
               fmt_code_in = {b, fmt_code_ff[7:0]};
            end else if (fmt_off == 34'd14) begin
               sbw_in = {8'd0, b};
            end else if (fmt_off == 34'd15) begin
               sbw_in   = {b, sbw_ff[7:0]};
               cend_in  = hw_ff[32:0];
               phase_in = (hw_ff[32:0] == pos1) ? PH_HDR : PH_SKIP;
            end
         end
         PH_DATA: begin
            if (held_ff == 2'd0 && data_left < {30'd0, w_dec}) begin
               res_cnt = 3'd1;
            end else if ({1'b0, held_ff} + 3'd1 < w_dec) begin
               unique case (held_ff)
                  2'd0:    hold_in = {hold_ff[23:8], b};
                  2'd1:    hold_in = {hold_ff[23:16], b, hold_ff[7:0]};
                  default: hold_in = {b, hold_ff[15:0]};
               endcase
               held_in = held_ff + 2'd1;
               res_cnt = 3'd0;
            end else begin
               res_bytes = raw;
               res_cnt   = w_dec;
               res_scale = (vol_ff < VOL_PASS_LIMIT);
               held_in   = 2'd0;
               hold_in   = 24'd0;
            end
            if (pos1 >= cend_ff) begin
               phase_in = PH_PASS;
            end
         end
         default: begin
         end
      endcase

      pos_in = pos1[31:0];
      if (is_end) begin
         pos_in      = 32'd0;
         phase_in    = PH_RIFF;
         hw_in       = 64'd0;
         cend_in     = 33'd0;
         fmt_seen_in = 1'b0;
         fmt_code_in = 16'd0;
         sbw_in      = 16'd0;
         hold_in     = 24'd0;
         held_in     = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_RIFF;
         pos_ff      <= 32'd0;
         len_ff      <= 32'd0;
         hw_ff       <= 64'd0;
         cend_ff     <= 33'd0;
         fmt_seen_ff <= 1'b0;
         fmt_code_ff <= 16'd0;
         sbw_ff      <= 16'd0;
         hold_ff     <= 24'd0;
         held_ff     <= 2'd0;
      end else if (accept) begin
         phase_ff    <= phase_in;
         pos_ff      <= pos_in;
         len_ff      <= len_in;
         hw_ff       <= hw_in;
         cend_ff     <= cend_in;
         fmt_seen_ff <= fmt_seen_in;
         fmt_code_ff <= fmt_code_in;
         sbw_ff      <= sbw_in;
         hold_ff     <= hold_in;
         held_ff     <= held_in;
      end
   end

   // Parse register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      s1_bytes_ff <= res_bytes;
      s1_cnt_ff   <= res_cnt;
      s1_end_ff   <= is_end;
      s1_scale_ff <= res_scale;
      s1_w_ff     <= w_dec;
      s1_x_ff     <= res_x;
   end

   // Multiplier register.
   assign s2_prod_in = s1_x_ff * signed'({1'b0, vol_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_bytes_ff <= s1_bytes_ff;
      s2_cnt_ff   <= s1_cnt_ff;
      s2_end_ff   <= s1_end_ff;
      s2_scale_ff <= s1_scale_ff;
      s2_w_ff     <= s1_w_ff;
      s2_prod_ff  <= s2_prod_in;
   end

   // 8-bit samples floor, wider samples truncate toward zero; all saturate.
   always_comb begin
      prod_bias = s2_prod_ff + (s2_prod_ff[48] ? 49'sd32767 : 49'sd0);
      q_floor   = s2_prod_ff[48:15];
      q_trunc   = prod_bias[48:15];
      q_off     = q_floor + 34'sd128;
      unique case (s2_w_ff)
         3'd1: begin
            if (q_off < 34'sd0) begin
               scaled = 32'd0;
            end else if (q_off > 34'sd255) begin
               scaled = 32'd255;
            end else begin
               scaled = {24'd0, q_off[7:0]};
            end
         end
         3'd2: begin
            if (q_trunc < -34'sd32768) begin
               scaled = 32'h0000_8000;
            end else if (q_trunc > 34'sd32767) begin
               scaled = 32'h0000_7FFF;
            end else begin
               scaled = {16'd0, q_trunc[15:0]};
            end
         end
         3'd3: begin
            if (q_trunc < -34'sd8388608) begin
               scaled = 32'h0080_0000;
            end else if (q_trunc > 34'sd8388607) begin
               scaled = 32'h007F_FFFF;
            end else begin
               scaled = {8'd0, q_trunc[23:0]};
            end
         end
         default: begin
            if (q_trunc < -34'sd2147483648) begin
               scaled = 32'h8000_0000;
            end else if (q_trunc > 34'sd2147483647) begin
               scaled = 32'h7FFF_FFFF;
            end else begin
               scaled = q_trunc[31:0];
            end
         end
      endcase
   end

   // Run queue and byte serialiser.
   assign push           = s2_valid_ff && (s2_cnt_ff != 3'd0);
   assign push_word      = '{bytes:    (s2_scale_ff ? scaled : s2_bytes_ff),
                             count:    s2_cnt_ff,
                             file_end: s2_end_ff};
   assign head           = fifo_mem[rd_ptr_ff];
   assign rsp_tvalid     = (cnt_ff != '0);
   assign rsp_acc        = rsp_tvalid && rsp_tready;
   assign rsp_tlast      = ({1'b0, sel_ff} == head.count - 3'd1);
   assign rsp_tuser      = rsp_tlast && head.file_end;
   assign pop            = rsp_acc && rsp_tlast;
   assign credit_used    = {1'b0, cnt_ff} + {{CntW{1'b0}}, s1_valid_ff} +
                           {{CntW{1'b0}}, s2_valid_ff};
   assign req_tready     = (credit_used < (CntW + 1)'(FifoDepth));

   always_comb begin
      unique case (sel_ff)
         2'd0:    rsp_tdata = head.bytes[7:0];
         2'd1:    rsp_tdata = head.bytes[15:8];
         2'd2:    rsp_tdata = head.bytes[23:16];
         default: rsp_tdata = head.bytes[31:24];
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_mem[wr_ptr_ff] <= push_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
         sel_ff    <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PtrW'(FifoDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PtrW'(FifoDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
            sel_ff    <= 2'd0;
         end else if (rsp_acc) begin
            sel_ff <= sel_ff + 2'd1;
         end
         cnt_ff <= cnt_ff + CntW'(push) - CntW'(pop);
      end
   end

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CntW'(FifoDepth))
      else $error("run queue count beyond its depth");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> (cnt_ff != CntW'(FifoDepth)) || pop)
      else $error("run pushed into a full queue");

   a_head_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (head.count != 3'd0) && ({1'b0, sel_ff} < head.count))
      else $error("serialiser beyond the run length");

   a_held_below_width: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DATA) |-> ({1'b0, held_ff} < w_dec))
      else $error("held byte count reached the sample width");

   a_file_restart: assert property (@(posedge clock) disable iff (reset)
      (accept && is_end) |=> (pos_ff == 32'd0) && (phase_ff == PH_RIFF))
      else $error("parser did not restart after the last byte of a file");

endmodule
